/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/ufrc_pkg.sv */
package ufrc_pkg;

  // table sizes
  localparam int MAX_ELEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = 11;
  localparam int RANK_W    = 4;

  localparam logic [RANK_W-1:0] RANK_MAX    = '1;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
  localparam logic [IDX_W-1:0]  CLR_LAST    = IDX_W'(MAX_ELEMS - 1);

  // microprogram addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_CLR    = 4'd0;
  localparam logic [PC_W-1:0] ST_IDLE   = 4'd1;
  localparam logic [PC_W-1:0] ST_CHECK  = 4'd2;
  localparam logic [PC_W-1:0] ST_WALK_A = 4'd3;
  localparam logic [PC_W-1:0] ST_CST_A  = 4'd4;
  localparam logic [PC_W-1:0] ST_COMP_A = 4'd5;
  localparam logic [PC_W-1:0] ST_SAVE_A = 4'd6;
  localparam logic [PC_W-1:0] ST_WALK_B = 4'd7;
  localparam logic [PC_W-1:0] ST_CST_B  = 4'd8;
  localparam logic [PC_W-1:0] ST_COMP_B = 4'd9;
  localparam logic [PC_W-1:0] ST_SAVE_B = 4'd10;
  localparam logic [PC_W-1:0] ST_LINK   = 4'd11;
  localparam logic [PC_W-1:0] ST_DONE   = 4'd12;
  localparam logic [PC_W-1:0] ST_BAD    = 4'd13;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
  localparam logic [OP_W-1:0] OP_CAPTURE = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_A  = 4'd3;
  localparam logic [OP_W-1:0] OP_WALK    = 4'd4;
  localparam logic [OP_W-1:0] OP_CST_A   = 4'd5;
  localparam logic [OP_W-1:0] OP_COMP    = 4'd6;
  localparam logic [OP_W-1:0] OP_SAVE_A  = 4'd7;
  localparam logic [OP_W-1:0] OP_CST_B   = 4'd8;
  localparam logic [OP_W-1:0] OP_SAVE_B  = 4'd9;
  localparam logic [OP_W-1:0] OP_LINK    = 4'd10;
  localparam logic [OP_W-1:0] OP_DONE    = 4'd11;
  localparam logic [OP_W-1:0] OP_BAD     = 4'd12;

  // jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER        = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS       = 4'd1;
  localparam logic [COND_W-1:0] C_CLR_MORE     = 4'd2;
  localparam logic [COND_W-1:0] C_NO_START     = 4'd3;
  localparam logic [COND_W-1:0] C_BAD          = 4'd4;
  localparam logic [COND_W-1:0] C_NOT_ROOT     = 4'd5;
  localparam logic [COND_W-1:0] C_A_ROOT       = 4'd6;
  localparam logic [COND_W-1:0] C_B_ROOT       = 4'd7;
  localparam logic [COND_W-1:0] C_PRD_NOT_ROOT = 4'd8;
  localparam logic [COND_W-1:0] C_NO_LINK      = 4'd9;

  // one control word: operation, jump condition, jump target
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   tgt;
  } uword_t;

  // control store; a false condition falls through to the next step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      ST_CLR:    w = '{OP_CLEAR,   C_CLR_MORE,     ST_CLR};
      ST_IDLE:   w = '{OP_CAPTURE, C_NO_START,     ST_IDLE};
      ST_CHECK:  w = '{OP_LOAD_A,  C_BAD,          ST_BAD};
      ST_WALK_A: w = '{OP_WALK,    C_NOT_ROOT,     ST_WALK_A};
      ST_CST_A:  w = '{OP_CST_A,   C_A_ROOT,       ST_SAVE_A};
      ST_COMP_A: w = '{OP_COMP,    C_PRD_NOT_ROOT, ST_COMP_A};
      ST_SAVE_A: w = '{OP_SAVE_A,  C_NEVER,        ST_IDLE};
      ST_WALK_B: w = '{OP_WALK,    C_NOT_ROOT,     ST_WALK_B};
      ST_CST_B:  w = '{OP_CST_B,   C_B_ROOT,       ST_SAVE_B};
      ST_COMP_B: w = '{OP_COMP,    C_PRD_NOT_ROOT, ST_COMP_B};
      ST_SAVE_B: w = '{OP_SAVE_B,  C_NO_LINK,      ST_DONE};
      ST_LINK:   w = '{OP_LINK,    C_NEVER,        ST_IDLE};
      ST_DONE:   w = '{OP_DONE,    C_ALWAYS,       ST_IDLE};
      ST_BAD:    w = '{OP_BAD,     C_ALWAYS,       ST_IDLE};
      default:   w = '{OP_NONE,    C_ALWAYS,       ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/union_find_rank_compress.sv */
// A result strobe follows each start that is taken, once the paths from elem_a and
// elem_b to their roots have been walked and compressed; a link adds one more step.
// Rejected indices give the strobe without a walk. One parent table access per cycle
// sets the walk rate; a new word is taken in the cycle of the previous strobe.
// Reset: synchronous, active low; afterwards busy stays high while the tables are swept
// to their initial contents. The receiver cannot stall.
`include "assert_macros.svh"

module union_find_rank_compress
  import ufrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [IDX_W-1:0] in_elem_a,
  input  logic [IDX_W-1:0] in_elem_b,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_root_a,
  output logic [IDX_W-1:0] out_root_b,
  output logic             out_same_set,
  output logic [IDX_W-1:0] out_final_root,
  output logic             out_bad_index,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_element_count
);

  // tables
  logic [IDX_W-1:0]  parent_mem [MAX_ELEMS];
  logic [RANK_W-1:0] rank_mem   [MAX_ELEMS];

  // control registers
  logic [PC_W-1:0]  upc_r, upc_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] cfg_count_r;
  logic             out_valid_r, out_valid_nxt;

  // datapath registers
  logic [IDX_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic              merge_r, merge_nxt, bad_r, bad_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt, rt_r, rt_nxt;
  logic [IDX_W-1:0]  ra_r, ra_nxt, rb_r, rb_nxt, fin_r, fin_nxt;
  logic [IDX_W-1:0]  prd_r;
  logic [RANK_W-1:0] rka_r, rkb_r;
  logic [IDX_W-1:0]  o_ra_r, o_ra_nxt, o_rb_r, o_rb_nxt, o_fin_r, o_fin_nxt;
  logic              o_same_r, o_same_nxt, o_bad_r, o_bad_nxt;

  // memory port controls
  logic              pwe, rwe;
  logic [IDX_W-1:0]  pwa, pwd, pra, rwa;
  logic [RANK_W-1:0] rwd;

  uword_t uw;
  logic   jmp;
  logic   in_bad;

  assign uw        = ucode_rom(upc_r);
  assign busy      = (upc_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_bad    = (CNT_W'(in_elem_a) >= cfg_count_r) || (CNT_W'(in_elem_b) >= cfg_count_r);

  // jump condition
  always_comb begin
    case (uw.cond)
      C_NEVER:        jmp = 1'b0;
      C_ALWAYS:       jmp = 1'b1;
      C_CLR_MORE:     jmp = (clr_r != CLR_LAST);
      C_NO_START:     jmp = !start;
      C_BAD:          jmp = bad_r;
      C_NOT_ROOT:     jmp = (prd_r != cur_r);
      C_A_ROOT:       jmp = (a_r == rt_r);
      C_B_ROOT:       jmp = (b_r == rt_r);
      C_PRD_NOT_ROOT: jmp = (prd_r != rt_r);
      C_NO_LINK:      jmp = !merge_r || (ra_r == rt_r);
      default:        jmp = 1'b0;
    endcase
    upc_nxt = jmp ? uw.tgt : upc_r + 1'b1;
  end

  // datapath driven by the current control word
  always_comb begin
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    a_nxt         = a_r;
    b_nxt         = b_r;
    merge_nxt     = merge_r;
    bad_nxt       = bad_r;
    cur_nxt       = cur_r;
    rt_nxt        = rt_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    fin_nxt       = fin_r;
    o_ra_nxt      = o_ra_r;
    o_rb_nxt      = o_rb_r;
    o_fin_nxt     = o_fin_r;
    o_same_nxt    = o_same_r;
    o_bad_nxt     = o_bad_r;
    pwe           = 1'b0;
    pwa           = cur_r;
    pwd           = rt_r;
    pra           = prd_r;
    rwe           = 1'b0;
    rwa           = ra_r;
    rwd           = rka_r + 1'b1;
    case (uw.op)
      OP_CLEAR: begin
        pwe     = 1'b1;
        pwa     = clr_r;
        pwd     = clr_r;
        rwe     = 1'b1;
        rwa     = clr_r;
        rwd     = '0;
        clr_nxt = clr_r + 1'b1;
      end
      OP_CAPTURE: begin
        if (start) begin
          a_nxt     = in_elem_a;
          b_nxt     = in_elem_b;
          merge_nxt = in_req_type;
          bad_nxt   = in_bad;
        end
      end
      OP_LOAD_A, OP_CST_A: begin
        cur_nxt = a_r;
        pra     = a_r;
      end
      // root walk: follow the parent until it points at itself
      OP_WALK: begin
        if (prd_r == cur_r) begin
          rt_nxt = cur_r;
        end else begin
          cur_nxt = prd_r;
          pra     = prd_r;
        end
      end
      // compression: repoint this node, fetch the next one up
      OP_COMP: begin
        pwe     = 1'b1;
        pwa     = cur_r;
        pwd     = rt_r;
        cur_nxt = prd_r;
        pra     = prd_r;
      end
      OP_SAVE_A, OP_CST_B: begin
        if (uw.op == OP_SAVE_A) begin
          ra_nxt = rt_r;
        end
        cur_nxt = b_r;
        pra     = b_r;
      end
      OP_SAVE_B: begin
        rb_nxt  = rt_r;
        fin_nxt = ra_r;
      end
      // union by rank
      OP_LINK: begin
        pwe = 1'b1;
        if (rka_r < rkb_r) begin
          pwa     = ra_r;
          pwd     = rb_r;
          fin_nxt = rb_r;
        end else begin
          pwa = rb_r;
          pwd = ra_r;
          rwe = (rka_r == rkb_r) && (rka_r != RANK_MAX);
        end
      end
      OP_DONE: begin
        out_valid_nxt = 1'b1;
        o_ra_nxt      = ra_r;
        o_rb_nxt      = rb_r;
        o_same_nxt    = (ra_r == rb_r);
        o_fin_nxt     = fin_r;
        o_bad_nxt     = 1'b0;
      end
      OP_BAD: begin
        out_valid_nxt = 1'b1;
        o_ra_nxt      = '0;
        o_rb_nxt      = '0;
        o_same_nxt    = 1'b0;
        o_fin_nxt     = '0;
        o_bad_nxt     = 1'b1;
      end
      default: begin
        pwe = 1'b0;
      end
    endcase
  end

  // parent table, registered read
  always_ff @(posedge clk) begin
    if (pwe) begin
      parent_mem[pwa] <= pwd;
    end
    prd_r <= parent_mem[pra];
  end

  // rank table, read at both roots
  always_ff @(posedge clk) begin
    if (rwe) begin
      rank_mem[rwa] <= rwd;
    end
    rka_r <= rank_mem[ra_r];
    rkb_r <= rank_mem[rt_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_CLR;
      clr_r       <= '0;
      cfg_count_r <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_count_r <= cfg_element_count;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    merge_r  <= merge_nxt;
    bad_r    <= bad_nxt;
    cur_r    <= cur_nxt;
    rt_r     <= rt_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    fin_r    <= fin_nxt;
    o_ra_r   <= o_ra_nxt;
    o_rb_r   <= o_rb_nxt;
    o_fin_r  <= o_fin_nxt;
    o_same_r <= o_same_nxt;
    o_bad_r  <= o_bad_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_root_a     = o_ra_r;
  assign out_root_b     = o_rb_r;
  assign out_same_set   = o_same_r;
  assign out_final_root = o_fin_r;
  assign out_bad_index  = o_bad_r;

  // checks
  `ASSERT_CLK(a_strobe_src, out_valid_r |-> $past(upc_r == ST_DONE || upc_r == ST_BAD), "result strobe without a finishing step")
  `ASSERT_CLK(a_bad_path, (start && !busy && in_bad) |=> ##2 (out_valid && out_bad_index), "rejected word not reported in three cycles")
  `ASSERT_NEVER(a_self_link, (upc_r == ST_LINK) && (ra_r == rb_r), "link of a root to itself")
  `ASSERT_NEVER(a_comp_root, (upc_r == ST_COMP_A || upc_r == ST_COMP_B) && (cur_r == rt_r), "compression step on the root")

endmodule
